>>> hdl/tqe_pkg.sv
// Package for the timer queue expiry engine: field widths, codes and
// transaction payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tqe_pkg;

   localparam int EXP_W     = 48;
   localparam int PER_W     = 32;
   localparam int WORD_W    = 32;
   localparam int MAX_FIRES = 32;
   localparam int LOG_W     = $clog2(MAX_FIRES);

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_RESET  = 2'd2,
      ACT_RUN    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_ADD_ACK    = 3'd0,
      KIND_DELETE_ACK = 3'd1,
      KIND_RESET_ACK  = 3'd2,
      KIND_FIRED      = 3'd3,
      KIND_RUN_DONE   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NO_TIMER = 2'd2
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [3:0]          timer_id;
      logic [EXP_W-1:0]    expire_at;
      logic [PER_W-1:0]    period;
      logic [WORD_W-1:0]   context_word;
      logic [WORD_W-1:0]   user_word;
      logic [EXP_W-1:0]    now_time;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      status_type          status;
      logic [3:0]          slot_id;
      logic [WORD_W-1:0]   fired_context;
      logic [WORD_W-1:0]   fired_user;
      logic [5:0]          fired_count;
      logic                last;
      logic [4:0]          active_count;
      logic                none_active;
      logic [3:0]          earliest_slot;
      logic [EXP_W-1:0]    earliest_expire;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/tqe_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on tqe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface tqe_req_if;
   logic             valid;
   logic             ready;
   tqe_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tqe_rsp_if;
   logic             valid;
   logic             ready;
   tqe_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tqe_rem.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit a cycle.
// Depends on tqe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tqe_rem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tqe_pkg::EXP_W-1:0]   dividend,
   input  wire logic [tqe_pkg::PER_W-1:0]   divisor,
   output logic                             done,
   output logic [tqe_pkg::PER_W-1:0]        remainder
);
   localparam int CNT_W = $clog2(tqe_pkg::EXP_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [tqe_pkg::EXP_W-1:0]   dvd_ff;
   logic [tqe_pkg::PER_W-1:0]   rem_ff;
   logic [tqe_pkg::PER_W:0]     shifted;
   logic [tqe_pkg::PER_W-1:0]   rem_in;

   assign shifted = {rem_ff, dvd_ff[tqe_pkg::EXP_W-1]};

   always_comb begin
      if (shifted >= {1'b0, divisor}) begin
         rem_in = tqe_pkg::PER_W'(shifted - {1'b0, divisor});
      end else begin
         rem_in = shifted[tqe_pkg::PER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(tqe_pkg::EXP_W - 1);
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[tqe_pkg::EXP_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> hdl/timer_queue_expiry_engine.sv
// Timer slot table with expiry engine: slot memories, scan sequencer and
// response staging. Depends on tqe_pkg, tqe_if and tqe_rem.
//
//   channel  direction  handshake      payload
//   req_if   in         valid/ready    tqe_pkg::req_type
//   rsp_if   out        valid/ready    tqe_pkg::rsp_type
//
// One transaction at a time. Add, delete and reset each end with a scan of the
// expiry memory, one slot a cycle. A run rescans after each fired one-shot timer
// and ends with one final scan; a fired periodic timer first passes through the
// serial remainder unit and a write-back state before its rescan.
// Each fired result is staged through a read state and a load state. No clearing
// pass after reset. A stalled response holds all state; the next request waits for
// the last.
`timescale 1ns / 1ps
`default_nettype none
module timer_queue_expiry_engine #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tqe_req_if.sink    req_if,
   tqe_rsp_if.source  rsp_if
);
   localparam int SW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   typedef struct packed {
      logic [tqe_pkg::EXP_W-1:0] expire;
      logic [tqe_pkg::PER_W-1:0] period;
   } tp_entry_type;

   typedef struct packed {
      logic [tqe_pkg::WORD_W-1:0] ctx;
      logic [tqe_pkg::WORD_W-1:0] usr;
   } cu_entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_OP, S_SCAN, S_FIRE, S_DIV, S_WRITE,
      S_EMIT, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
   } state_type;

   state_type                   state_ff;

   // latched request
   tqe_pkg::action_type         act_ff;
   logic [3:0]                  tid_ff;
   logic [tqe_pkg::EXP_W-1:0]   exp_ff;
   logic [tqe_pkg::PER_W-1:0]   per_ff;
   logic [tqe_pkg::WORD_W-1:0]  ctx_ff;
   logic [tqe_pkg::WORD_W-1:0]  usr_ff;
   logic [tqe_pkg::EXP_W-1:0]   now_ff;

   logic [TIMER_SLOTS-1:0]      valid_ff;
   logic [CW-1:0]               active_ff;
   logic [SW-1:0]               free_ff;
   logic                        full_ff;
   logic                        free_seen_ff;

   logic [CW-1:0]               scan_cnt_ff;
   logic                        dv_ff;
   logic [SW-1:0]               didx_ff;
   logic                        found_ff;
   logic [SW-1:0]               best_slot_ff;
   logic [tqe_pkg::EXP_W-1:0]   best_exp_ff;
   logic [tqe_pkg::PER_W-1:0]   best_per_ff;

   logic [5:0]                  fired_ff;
   logic [SW-1:0]               log_ff [tqe_pkg::MAX_FIRES];
   logic [5:0]                  emit_k_ff;
   logic [tqe_pkg::EXP_W-1:0]   d_ff;
   logic                        div_start_ff;

   tqe_pkg::status_type         ack_status_ff;
   logic [3:0]                  ack_slot_ff;

   logic                        out_valid_ff;
   tqe_pkg::kind_type           out_kind_ff;
   tqe_pkg::status_type         out_status_ff;
   logic [3:0]                  out_slot_ff;
   logic [tqe_pkg::WORD_W-1:0]  out_ctx_ff;
   logic [tqe_pkg::WORD_W-1:0]  out_usr_ff;
   logic [5:0]                  out_cnt_ff;
   logic                        out_last_ff;

   // memories
   tp_entry_type                tp_mem [TIMER_SLOTS];
   cu_entry_type                cu_mem [TIMER_SLOTS];
   tp_entry_type                tp_rd_ff;
   cu_entry_type                cu_rd_ff;
   logic                        tp_we;
   logic                        cu_we;
   logic [SW-1:0]               wr_addr;
   tp_entry_type                tp_wd;
   cu_entry_type                cu_wd;
   logic [SW-1:0]               tp_ra;
   logic [SW-1:0]               cu_ra;

   logic                        id_live;
   logic [SW-1:0]               tid_idx;
   logic                        is_run;
   logic                        div_done;
   logic [tqe_pkg::PER_W-1:0]   div_rem;
   logic [tqe_pkg::PER_W-1:0]   addend;
   logic [tqe_pkg::EXP_W:0]     sum;
   logic [tqe_pkg::EXP_W-1:0]   ne_in;
   tqe_pkg::kind_type           ack_kind;

   assign tid_idx = SW'(tid_ff);
   assign id_live = (32'(tid_ff) < TIMER_SLOTS) && valid_ff[tid_idx];
   assign is_run  = (act_ff == tqe_pkg::ACT_RUN);

   tqe_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (d_ff),
      .divisor   (best_per_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // catch-up: land on the first period boundary past the fired expiry that is at or after now
   always_comb begin
      if (d_ff == '0) begin
         addend = best_per_ff;
      end else if (div_rem == '0) begin
         addend = '0;
      end else begin
         addend = best_per_ff - div_rem;
      end
      sum   = {1'b0, now_ff} + (tqe_pkg::EXP_W + 1)'(addend);
      ne_in = sum[tqe_pkg::EXP_W] ? '1 : sum[tqe_pkg::EXP_W-1:0];
   end

   always_comb begin
      tp_we   = 1'b0;
      cu_we   = 1'b0;
      wr_addr = best_slot_ff;
      tp_wd   = '{expire: exp_ff, period: per_ff};
      cu_wd   = '{ctx: ctx_ff, usr: usr_ff};
      if (state_ff == S_OP) begin
         if (act_ff == tqe_pkg::ACT_ADD && !full_ff) begin
            tp_we   = 1'b1;
            cu_we   = 1'b1;
            wr_addr = free_ff;
         end else if (act_ff == tqe_pkg::ACT_RESET && id_live) begin
            tp_we   = 1'b1;
            cu_we   = 1'b1;
            wr_addr = tid_idx;
         end
      end else if (state_ff == S_WRITE) begin
         tp_we = 1'b1;
         tp_wd = '{expire: ne_in, period: best_per_ff};
      end
   end

   assign tp_ra = scan_cnt_ff[SW-1:0];
   assign cu_ra = log_ff[emit_k_ff[tqe_pkg::LOG_W-1:0]];

   always_ff @(posedge clock) begin
      if (tp_we) begin
         tp_mem[wr_addr] <= tp_wd;
      end
      if (cu_we) begin
         cu_mem[wr_addr] <= cu_wd;
      end
      tp_rd_ff <= tp_mem[tp_ra];
      cu_rd_ff <= cu_mem[cu_ra];
   end

   always_comb begin
      case (act_ff)
         tqe_pkg::ACT_ADD:    ack_kind = tqe_pkg::KIND_ADD_ACK;
         tqe_pkg::ACT_DELETE: ack_kind = tqe_pkg::KIND_DELETE_ACK;
         tqe_pkg::ACT_RESET:  ack_kind = tqe_pkg::KIND_RESET_ACK;
         default:             ack_kind = tqe_pkg::KIND_RUN_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         active_ff    <= '0;
         free_ff      <= '0;
         full_ff      <= 1'b0;
         found_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         fired_ff     <= '0;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  act_ff   <= req_if.data.action;
                  tid_ff   <= req_if.data.timer_id;
                  exp_ff   <= req_if.data.expire_at;
                  per_ff   <= req_if.data.period;
                  ctx_ff   <= req_if.data.context_word;
                  usr_ff   <= req_if.data.user_word;
                  now_ff   <= req_if.data.now_time;
                  state_ff <= S_OP;
               end
            end
            S_OP: begin
               case (act_ff)
                  tqe_pkg::ACT_ADD: begin
                     if (full_ff) begin
                        ack_status_ff <= tqe_pkg::STAT_FULL;
                        ack_slot_ff   <= '0;
                     end else begin
                        valid_ff[free_ff] <= 1'b1;
                        active_ff         <= active_ff + 1'b1;
                        ack_status_ff     <= tqe_pkg::STAT_OK;
                        ack_slot_ff       <= 4'(free_ff);
                     end
                  end
                  tqe_pkg::ACT_DELETE: begin
                     if (id_live) begin
                        valid_ff[tid_idx] <= 1'b0;
                        active_ff         <= active_ff - 1'b1;
                     end
                     ack_status_ff <= id_live ? tqe_pkg::STAT_OK : tqe_pkg::STAT_NO_TIMER;
                     ack_slot_ff   <= tid_ff;
                  end
                  tqe_pkg::ACT_RESET: begin
                     ack_status_ff <= id_live ? tqe_pkg::STAT_OK : tqe_pkg::STAT_NO_TIMER;
                     ack_slot_ff   <= tid_ff;
                  end
                  default: begin
                     fired_ff <= '0;
                  end
               endcase
               scan_cnt_ff  <= '0;
               dv_ff        <= 1'b0;
               found_ff     <= 1'b0;
               free_seen_ff <= 1'b0;
               state_ff     <= S_SCAN;
            end
            S_SCAN: begin
               // issue one read a cycle, compare the one that just came back
               if (scan_cnt_ff < CW'(TIMER_SLOTS)) begin
                  scan_cnt_ff <= scan_cnt_ff + 1'b1;
                  dv_ff       <= 1'b1;
                  didx_ff     <= scan_cnt_ff[SW-1:0];
               end else begin
                  dv_ff <= 1'b0;
               end
               if (dv_ff) begin
                  if (valid_ff[didx_ff] && (!found_ff || tp_rd_ff.expire < best_exp_ff)) begin
                     found_ff     <= 1'b1;
                     best_slot_ff <= didx_ff;
                     best_exp_ff  <= tp_rd_ff.expire;
                     best_per_ff  <= tp_rd_ff.period;
                  end
                  if (!valid_ff[didx_ff] && !free_seen_ff) begin
                     free_seen_ff <= 1'b1;
                     free_ff      <= didx_ff;
                  end
               end
               if (scan_cnt_ff == CW'(TIMER_SLOTS) && !dv_ff) begin
                  full_ff <= !free_seen_ff;
                  if (is_run && found_ff && now_ff >= best_exp_ff &&
                      fired_ff < 6'(tqe_pkg::MAX_FIRES)) begin
                     state_ff <= S_FIRE;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_FIRE: begin
               log_ff[fired_ff[tqe_pkg::LOG_W-1:0]] <= best_slot_ff;
               fired_ff <= fired_ff + 1'b1;
               if (best_per_ff == '0) begin
                  // one-shot: free it and rescan
                  valid_ff[best_slot_ff] <= 1'b0;
                  active_ff    <= active_ff - 1'b1;
                  scan_cnt_ff  <= '0;
                  dv_ff        <= 1'b0;
                  found_ff     <= 1'b0;
                  free_seen_ff <= 1'b0;
                  state_ff     <= S_SCAN;
               end else begin
                  d_ff         <= now_ff - best_exp_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               scan_cnt_ff  <= '0;
               dv_ff        <= 1'b0;
               found_ff     <= 1'b0;
               free_seen_ff <= 1'b0;
               state_ff     <= S_SCAN;
            end
            S_EMIT: begin
               if (is_run && fired_ff != '0) begin
                  emit_k_ff <= '0;
                  state_ff  <= S_EMIT_RD;
               end else begin
                  out_kind_ff   <= ack_kind;
                  out_status_ff <= is_run ? tqe_pkg::STAT_OK : ack_status_ff;
                  out_slot_ff   <= is_run ? 4'd0 : ack_slot_ff;
                  out_ctx_ff    <= '0;
                  out_usr_ff    <= '0;
                  out_cnt_ff    <= '0;
                  out_last_ff   <= 1'b1;
                  out_valid_ff  <= 1'b1;
                  state_ff      <= S_EMIT_WAIT;
               end
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT_LD;
            end
            S_EMIT_LD: begin
               out_kind_ff   <= tqe_pkg::KIND_FIRED;
               out_status_ff <= tqe_pkg::STAT_OK;
               out_slot_ff   <= 4'(log_ff[emit_k_ff[tqe_pkg::LOG_W-1:0]]);
               out_ctx_ff    <= cu_rd_ff.ctx;
               out_usr_ff    <= cu_rd_ff.usr;
               out_cnt_ff    <= '0;
               out_last_ff   <= 1'b0;
               out_valid_ff  <= 1'b1;
               state_ff      <= S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
               if (rsp_if.ready) begin
                  if (out_last_ff) begin
                     out_valid_ff <= 1'b0;
                     state_ff     <= S_IDLE;
                  end else if (emit_k_ff + 1'b1 < fired_ff) begin
                     out_valid_ff <= 1'b0;
                     emit_k_ff    <= emit_k_ff + 1'b1;
                     state_ff     <= S_EMIT_RD;
                  end else begin
                     // close the run with its summary transaction
                     out_kind_ff   <= tqe_pkg::KIND_RUN_DONE;
                     out_status_ff <= tqe_pkg::STAT_OK;
                     out_slot_ff   <= '0;
                     out_ctx_ff    <= '0;
                     out_usr_ff    <= '0;
                     out_cnt_ff    <= fired_ff;
                     out_last_ff   <= 1'b1;
                     out_valid_ff  <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = out_valid_ff;

   always_comb begin
      rsp_if.data.kind            = out_kind_ff;
      rsp_if.data.status          = out_status_ff;
      rsp_if.data.slot_id         = out_slot_ff;
      rsp_if.data.fired_context   = out_ctx_ff;
      rsp_if.data.fired_user      = out_usr_ff;
      rsp_if.data.fired_count     = out_cnt_ff;
      rsp_if.data.last            = out_last_ff;
      rsp_if.data.active_count    = 5'(active_ff);
      rsp_if.data.none_active     = !found_ff;
      rsp_if.data.earliest_slot   = found_ff ? 4'(best_slot_ff) : 4'd0;
      rsp_if.data.earliest_expire = found_ff ? best_exp_ff : '0;
   end

   a_active_range: assert property (@(posedge clock) disable iff (reset)
      active_ff <= CW'(TIMER_SLOTS))
      else $error("active count beyond table size");

   a_fired_range: assert property (@(posedge clock) disable iff (reset)
      fired_ff <= 6'(tqe_pkg::MAX_FIRES))
      else $error("fire count beyond run limit");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.data.last |=> req_if.ready)
      else $error("engine not idle after final response");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !found_ff |-> active_ff == '0)
      else $error("no earliest timer while timers are live");
endmodule
`default_nettype wire

>>> tb/sv/timer_queue_expiry_engine_tb.sv
// Testbench for the timer queue expiry engine: directed and random add, delete,
// reset and run transactions checked against an in-bench slot-table predictor.
// Depends on tqe_pkg, tqe_if and the engine RTL.
`timescale 1ns / 1ps
`default_nettype none
module timer_queue_expiry_engine_tb;

   localparam int SLOTS = 16;
   localparam longint CYCLE_LIMIT = 10000000;

   logic clock;
   logic reset;

   tqe_req_if req_if ();
   tqe_rsp_if rsp_if ();

   timer_queue_expiry_engine #(.TIMER_SLOTS(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // predictor copy of the slot table
   bit                         slot_live [SLOTS];
   logic [tqe_pkg::EXP_W-1:0]  slot_exp  [SLOTS];
   logic [tqe_pkg::PER_W-1:0]  slot_per  [SLOTS];
   logic [tqe_pkg::WORD_W-1:0] slot_ctx  [SLOTS];
   logic [tqe_pkg::WORD_W-1:0] slot_usr  [SLOTS];

   tqe_pkg::rsp_type pending_events[$];
   int      mismatches;
   int      events_seen;
   int      fires_seen;
   int      items_sent;
   longint  cycle_count;
   bit      rsp_hold;
   int      hold_cycles;
   bit      no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic int earliest_slot_of();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot_live[i] && (best < 0 || slot_exp[i] < slot_exp[best])) best = i;
      return best;
   endfunction

   function automatic tqe_pkg::rsp_type make_event(tqe_pkg::kind_type k,
                                                   tqe_pkg::status_type s,
                                                   logic [3:0] id,
                                                   logic [tqe_pkg::WORD_W-1:0] c,
                                                   logic [tqe_pkg::WORD_W-1:0] u,
                                                   logic [5:0] n);
      tqe_pkg::rsp_type r;
      r = '0;
      r.kind = k;
      r.status = s;
      r.slot_id = id;
      r.fired_context = c;
      r.fired_user = u;
      r.fired_count = n;
      return r;
   endfunction

   // advance the table by one request and queue the events it causes
   task automatic predict_timer_events(input tqe_pkg::req_type q);
      tqe_pkg::rsp_type evs[$];
      int         free_slot;
      int         best;
      int         fired;
      int         active;
      bit         id_live;
      logic [63:0] gap, steps, next_exp;
      id_live = slot_live[q.timer_id];
      case (q.action)
         tqe_pkg::ACT_ADD: begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
               if (!slot_live[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
               evs.push_back(make_event(tqe_pkg::KIND_ADD_ACK, tqe_pkg::STAT_FULL, 4'd0,
                                        '0, '0, '0));
            end else begin
               slot_live[free_slot] = 1'b1;
               slot_exp[free_slot] = q.expire_at;
               slot_per[free_slot] = q.period;
               slot_ctx[free_slot] = q.context_word;
               slot_usr[free_slot] = q.user_word;
               evs.push_back(make_event(tqe_pkg::KIND_ADD_ACK, tqe_pkg::STAT_OK,
                                        4'(free_slot), '0, '0, '0));
            end
         end
         tqe_pkg::ACT_DELETE: begin
            if (id_live) slot_live[q.timer_id] = 1'b0;
            evs.push_back(make_event(tqe_pkg::KIND_DELETE_ACK,
                                     id_live ? tqe_pkg::STAT_OK : tqe_pkg::STAT_NO_TIMER,
                                     q.timer_id, '0, '0, '0));
         end
         tqe_pkg::ACT_RESET: begin
            if (id_live) begin
               slot_exp[q.timer_id] = q.expire_at;
               slot_per[q.timer_id] = q.period;
               slot_ctx[q.timer_id] = q.context_word;
               slot_usr[q.timer_id] = q.user_word;
            end
            evs.push_back(make_event(tqe_pkg::KIND_RESET_ACK,
                                     id_live ? tqe_pkg::STAT_OK : tqe_pkg::STAT_NO_TIMER,
                                     q.timer_id, '0, '0, '0));
         end
         default: begin
            fired = 0;
            while (fired < tqe_pkg::MAX_FIRES) begin
               best = earliest_slot_of();
               if (best < 0 || q.now_time < slot_exp[best]) break;
               evs.push_back(make_event(tqe_pkg::KIND_FIRED, tqe_pkg::STAT_OK, 4'(best),
                                        slot_ctx[best], slot_usr[best], '0));
               if (slot_per[best] != 0) begin
                  gap = 64'(q.now_time) - 64'(slot_exp[best]);
                  steps = (gap + 64'(slot_per[best]) - 1) / 64'(slot_per[best]);
                  if (steps == 0) steps = 1;
                  next_exp = 64'(slot_exp[best]) + steps * 64'(slot_per[best]);
                  slot_exp[best] = (next_exp > 64'hFFFF_FFFF_FFFF) ? '1 : next_exp[47:0];
               end else begin
                  slot_live[best] = 1'b0;
               end
               fired++;
            end
            evs.push_back(make_event(tqe_pkg::KIND_RUN_DONE, tqe_pkg::STAT_OK, 4'd0,
                                     '0, '0, 6'(fired)));
         end
      endcase
      active = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_live[i]) active++;
      best = earliest_slot_of();
      foreach (evs[k]) begin
         evs[k].last = (k == evs.size() - 1);
         evs[k].active_count = 5'(active);
         evs[k].none_active = (best < 0);
         evs[k].earliest_slot = (best < 0) ? 4'd0 : 4'(best);
         evs[k].earliest_expire = (best < 0) ? '0 : slot_exp[best];
         pending_events.push_back(evs[k]);
      end
   endtask

   function automatic int random_gap();
      if (no_idle) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7, 8:    return $urandom_range(1, 3);
         default:       return $urandom_range(10, 60);
      endcase
   endfunction

   // offer one request and hold it until accepted; drop valid only over a gap
   task automatic send_request(input tqe_pkg::req_type q);
      int gap_cycles;
      gap_cycles = random_gap();
      if (gap_cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= q;
      do @(posedge clock); while (!req_if.ready);
      predict_timer_events(q);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic tqe_pkg::req_type new_timer(logic [tqe_pkg::EXP_W-1:0] e,
                                                  logic [tqe_pkg::PER_W-1:0] p);
      tqe_pkg::req_type q;
      q = '0;
      q.action = tqe_pkg::ACT_ADD;
      q.expire_at = e;
      q.period = p;
      q.context_word = $urandom;
      q.user_word = $urandom;
      return q;
   endfunction

   function automatic tqe_pkg::req_type timer_op(tqe_pkg::action_type a, logic [3:0] id,
                                                 logic [tqe_pkg::EXP_W-1:0] e,
                                                 logic [tqe_pkg::PER_W-1:0] p);
      tqe_pkg::req_type q;
      q = new_timer(e, p);
      q.action = a;
      q.timer_id = id;
      return q;
   endfunction

   function automatic tqe_pkg::req_type run_at(logic [tqe_pkg::EXP_W-1:0] now);
      tqe_pkg::req_type q;
      q = '0;
      q.action = tqe_pkg::ACT_RUN;
      q.now_time = now;
      q.expire_at = {16'($urandom), 32'($urandom)};
      return q;
   endfunction

   function automatic logic [tqe_pkg::EXP_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // response side: random stall, always ready under no_idle, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 9) < 7);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected event %p", rsp_if.data);
         end else begin
            if (rsp_if.data !== pending_events[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("event mismatch\n  expected %p\n  actual   %p",
                           pending_events[0], rsp_if.data);
            end
            void'(pending_events.pop_front());
         end
         events_seen++;
         if (rsp_if.data.kind == tqe_pkg::KIND_FIRED) fires_seen++;
      end
   end

   // long hold on the response side, counted in cycles
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_hold = 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_hold = 1'b0;
         end
      end
   end

   task automatic test_table_limits();
      send_request(run_at('0));
      send_request(timer_op(tqe_pkg::ACT_DELETE, 4'd0, '0, '0));
      send_request(timer_op(tqe_pkg::ACT_RESET, 4'd15, '1, '1));
      for (int i = 0; i < SLOTS; i++)
         send_request(new_timer((i == 0) ? '1 : 48'(1000 + i), (i == 1) ? '1 : 32'(0)));
      send_request(new_timer(48'd5, 32'd0));
      send_request(timer_op(tqe_pkg::ACT_RESET, 4'd3, 48'd1000, 32'd0));
      send_request(timer_op(tqe_pkg::ACT_DELETE, 4'd15, '0, '0));
      send_request(run_at(48'd999));
      wait_drained();
   endtask

   task automatic test_expiry_rules();
      // exact landing on now fires once more; saturation near the top
      send_request(run_at(48'd1010));
      send_request(timer_op(tqe_pkg::ACT_RESET, 4'd2, 48'd100, 32'd10));
      send_request(run_at(48'd200));
      send_request(timer_op(tqe_pkg::ACT_RESET, 4'd4, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF));
      send_request(timer_op(tqe_pkg::ACT_RESET, 4'd5, 48'd7, 32'd3));
      send_request(run_at('1));
      send_request(run_at('1));
      wait_drained();
      for (int i = 0; i < SLOTS; i++)
         send_request(timer_op(tqe_pkg::ACT_DELETE, 4'(i), '0, '0));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      tqe_pkg::req_type q;
      logic [tqe_pkg::EXP_W-1:0] clock_now;
      clock_now = 48'd1000;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: q = new_timer(clock_now + $urandom_range(0, 500),
                                   ($urandom_range(0, 1)) ? 32'($urandom_range(1, 200)) : 32'd0);
            3:       q = timer_op(tqe_pkg::ACT_DELETE, 4'($urandom), '0, '0);
            4:       q = timer_op(tqe_pkg::ACT_RESET, 4'($urandom),
                                  clock_now + $urandom_range(0, 300),
                                  32'($urandom_range(0, 50)));
            5:       q = timer_op(tqe_pkg::action_type'($urandom_range(0, 2)), 4'($urandom),
                                  rand48(), $urandom);
            6:       q = run_at(rand48());
            default: begin
               clock_now = clock_now + $urandom_range(0, 150);
               q = run_at(clock_now);
            end
         endcase
         if (q.action == tqe_pkg::ACT_ADD && $urandom_range(0, 9) == 0) q.expire_at = rand48();
         send_request(q);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 12; i++) send_request(new_timer(48'd50, 32'd0));
      send_request(run_at(48'd60));
      wait_drained();
      no_idle = 1'b1;
      for (int i = 0; i < 10; i++) send_request(run_at(48'd61));
      no_idle = 1'b0;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      mismatches = 0;
      events_seen = 0;
      fires_seen = 0;
      items_sent = 0;
      hold_cycles = 0;
      no_idle = 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_limits();
      test_expiry_rules();
      test_backpressure();
      test_random_traffic(260);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("sent %0d requests, checked %0d events including %0d timer firings",
               items_sent, events_seen, fires_seen);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d events missing", mismatches, pending_events.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
